FILE: rtl/core/ppps_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// ppps_pkg
// Shared types and codes of the preemptive priority playback scheduler.
// ============================================================================
package ppps_pkg;

    localparam int CLIENTS_DEF  = 16;
    localparam int POS_BITS_DEF = 32;

    // Port field widths
    localparam int KIND_W  = 2;
    localparam int ID_W    = 4;
    localparam int PRIO_W  = 8;
    localparam int POS_W   = 32;
    localparam int ACT_W   = 2;
    localparam int COUNT_W = 5;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_SUBMIT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;

    // Result actions
    localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_START = 2'd1;
    localparam logic [ACT_W-1:0] ACT_STOP  = 2'd2;

    // What a captured request does
    typedef enum logic [2:0] {
        CLS_NONE,
        CLS_START,
        CLS_REARM,
        CLS_PREEMPT,
        CLS_ENQUEUE,
        CLS_REMOVE,
        CLS_PROMOTE
    } cls_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DRAIN,
        ST_FETCH,
        ST_APPLY
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic scan_start;
        logic scan_step;
        logic apply;
    } dp_cmd_t;

    typedef struct packed {
        cls_t cls;
        logic scan_last;
        logic out_free;
    } dp_stat_t;

endpackage

FILE: rtl/core/ppps_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// ppps_ctrl
// Sequencer: capture, decode, pending-table scan, promote, result load.
// ============================================================================
module ppps_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ppps_pkg::dp_stat_t stat,
    output ppps_pkg::dp_cmd_t  cmd
);

    ppps_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ppps_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ppps_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = ppps_pkg::ST_EXEC;
                end
            end
            ppps_pkg::ST_EXEC: begin
                if (stat.cls == ppps_pkg::CLS_PROMOTE) begin
                    cmd.scan_start = 1'b1;
                    state_next     = ppps_pkg::ST_SCAN;
                end else if (stat.out_free) begin
                    cmd.exec   = 1'b1;
                    state_next = ppps_pkg::ST_IDLE;
                end
            end
            ppps_pkg::ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last) begin
                    state_next = ppps_pkg::ST_DRAIN;
                end
            end
            ppps_pkg::ST_DRAIN: begin
                state_next = ppps_pkg::ST_FETCH;
            end
            ppps_pkg::ST_FETCH: begin
                state_next = ppps_pkg::ST_APPLY;
            end
            ppps_pkg::ST_APPLY: begin
                if (stat.out_free) begin
                    cmd.apply  = 1'b1;
                    state_next = ppps_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ppps_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/ppps_dp.sv
`timescale 1ns / 1ps
// ============================================================================
// ppps_dp
// Request registers, current client, pending table and result register.
// ============================================================================
module ppps_dp #(
    parameter int CLIENTS       = ppps_pkg::CLIENTS_DEF,
    parameter int POSITION_BITS = ppps_pkg::POS_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ppps_pkg::dp_cmd_t            cmd,
    output ppps_pkg::dp_stat_t           stat,
    input  logic [ppps_pkg::KIND_W-1:0]  s_kind,
    input  logic [ppps_pkg::ID_W-1:0]    s_client_id,
    input  logic [ppps_pkg::PRIO_W-1:0]  s_priority_req,
    input  logic [ppps_pkg::POS_W-1:0]   s_current_position,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [ppps_pkg::ACT_W-1:0]   m_action,
    output logic [ppps_pkg::ID_W-1:0]    m_play_id,
    output logic [ppps_pkg::POS_W-1:0]   m_start_position,
    output logic                         m_playing,
    output logic [ppps_pkg::COUNT_W-1:0] m_pending_count
);

    localparam int IDX_W = $clog2(CLIENTS);
    localparam int CNT_W = $clog2(CLIENTS + 1);

    // Captured request
    logic [ppps_pkg::KIND_W-1:0] req_kind_reg;
    logic [ppps_pkg::ID_W-1:0]   req_id_reg;
    logic [ppps_pkg::PRIO_W-1:0] req_prio_reg;
    logic [ppps_pkg::POS_W-1:0]  req_pos_reg;
    logic [IDX_W-1:0]            req_idx;
    logic                        id_ok;

    // Current client and pending bookkeeping
    logic                        cur_valid_reg, cur_valid_next;
    logic [IDX_W-1:0]            cur_id_reg, cur_id_next;
    logic [ppps_pkg::PRIO_W-1:0] cur_prio_reg, cur_prio_next;
    logic [CLIENTS-1:0]          pend_valid_reg, pend_valid_next;
    logic [CNT_W-1:0]            count_reg, count_next;

    // Pending table storage, one write and one read port each
    logic [ppps_pkg::PRIO_W-1:0] prio_mem [CLIENTS];
    logic [POSITION_BITS-1:0]    pos_mem  [CLIENTS];
    logic                        wr_prio_en, wr_pos_en;
    logic [IDX_W-1:0]            wr_addr;
    logic [ppps_pkg::PRIO_W-1:0] wr_prio;
    logic [POSITION_BITS-1:0]    wr_pos;
    logic [IDX_W-1:0]            rd_addr;
    logic [ppps_pkg::PRIO_W-1:0] rd_prio_reg;
    logic [POSITION_BITS-1:0]    rd_pos_reg;

    // Scan for the best pending entry
    logic [IDX_W-1:0]            scan_idx_reg;
    logic                        cmp_active_reg;
    logic                        cmp_vld_reg;
    logic [IDX_W-1:0]            cmp_idx_reg;
    logic                        found_reg;
    logic [IDX_W-1:0]            best_idx_reg;
    logic [ppps_pkg::PRIO_W-1:0] best_prio_reg;

    // Result
    logic                         out_valid_reg;
    logic [ppps_pkg::ACT_W-1:0]   out_action_reg, res_action;
    logic [ppps_pkg::ID_W-1:0]    out_id_reg, res_id;
    logic [ppps_pkg::POS_W-1:0]   out_pos_reg, res_pos;
    logic                         out_playing_reg;
    logic [ppps_pkg::COUNT_W-1:0] out_count_reg;
    logic                         out_load;

    ppps_pkg::cls_t cls;

    assign req_idx = IDX_W'(req_id_reg);
    assign id_ok   = int'(req_id_reg) < CLIENTS;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_kind_reg <= s_kind;
            req_id_reg   <= s_client_id;
            req_prio_reg <= s_priority_req;
            req_pos_reg  <= s_current_position;
        end
    end

    // Request decode
    always_comb begin
        cls = ppps_pkg::CLS_NONE;
        priority if (req_kind_reg == ppps_pkg::KIND_FINISH) begin
            if (cur_valid_reg) begin
                cls = ppps_pkg::CLS_PROMOTE;
            end
        end else if (req_kind_reg == ppps_pkg::KIND_SUBMIT && id_ok) begin
            priority if (!cur_valid_reg || cur_id_reg == req_idx) begin
                cls = ppps_pkg::CLS_START;
            end else if (pend_valid_reg[req_idx]) begin
                cls = ppps_pkg::CLS_REARM;
            end else if (req_prio_reg > cur_prio_reg) begin
                cls = ppps_pkg::CLS_PREEMPT;
            end else begin
                cls = ppps_pkg::CLS_ENQUEUE;
            end
        end else if (req_kind_reg == ppps_pkg::KIND_CANCEL && id_ok) begin
            if (cur_valid_reg && cur_id_reg == req_idx) begin
                cls = ppps_pkg::CLS_PROMOTE;
            end else if (pend_valid_reg[req_idx]) begin
                cls = ppps_pkg::CLS_REMOVE;
            end
        end else begin
            // unused kind or client out of range
            cls = ppps_pkg::CLS_NONE;
        end
    end

    assign stat.cls       = cls;
    assign stat.scan_last = scan_idx_reg == IDX_W'(CLIENTS - 1);
    assign stat.out_free  = !out_valid_reg || m_ready;

    // Next state of the scheduler for the executed request or the applied promotion
    always_comb begin
        pend_valid_next = pend_valid_reg;
        cur_valid_next  = cur_valid_reg;
        cur_id_next     = cur_id_reg;
        cur_prio_next   = cur_prio_reg;
        count_next      = count_reg;
        wr_prio_en      = 1'b0;
        wr_pos_en       = 1'b0;
        wr_addr         = req_idx;
        wr_prio         = req_prio_reg;
        wr_pos          = '0;
        res_action      = ppps_pkg::ACT_NONE;
        res_id          = '0;
        res_pos         = '0;
        if (cmd.exec) begin
            unique case (cls)
                ppps_pkg::CLS_START: begin
                    if (pend_valid_reg[req_idx]) begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    pend_valid_next[req_idx] = 1'b0;
                    cur_valid_next = 1'b1;
                    cur_id_next    = req_idx;
                    cur_prio_next  = req_prio_reg;
                    res_action     = ppps_pkg::ACT_START;
                    res_id         = req_id_reg;
                end
                ppps_pkg::CLS_REARM: begin
                    wr_pos_en = 1'b1;
                end
                ppps_pkg::CLS_PREEMPT: begin
                    // current client goes back to the table with its position
                    pend_valid_next[cur_id_reg] = 1'b1;
                    count_next     = count_reg + CNT_W'(1);
                    wr_prio_en     = 1'b1;
                    wr_pos_en      = 1'b1;
                    wr_addr        = cur_id_reg;
                    wr_prio        = cur_prio_reg;
                    wr_pos         = POSITION_BITS'(req_pos_reg);
                    cur_valid_next = 1'b1;
                    cur_id_next    = req_idx;
                    cur_prio_next  = req_prio_reg;
                    res_action     = ppps_pkg::ACT_START;
                    res_id         = req_id_reg;
                end
                ppps_pkg::CLS_ENQUEUE: begin
                    pend_valid_next[req_idx] = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    wr_prio_en = 1'b1;
                    wr_pos_en  = 1'b1;
                end
                ppps_pkg::CLS_REMOVE: begin
                    pend_valid_next[req_idx] = 1'b0;
                    count_next = count_reg - CNT_W'(1);
                end
                default: begin
                end
            endcase
        end else if (cmd.apply) begin
            if (found_reg) begin
                pend_valid_next[best_idx_reg] = 1'b0;
                count_next     = count_reg - CNT_W'(1);
                cur_valid_next = 1'b1;
                cur_id_next    = best_idx_reg;
                cur_prio_next  = best_prio_reg;
                res_action     = ppps_pkg::ACT_START;
                res_id         = ppps_pkg::ID_W'(best_idx_reg);
                res_pos        = ppps_pkg::POS_W'(rd_pos_reg);
            end else begin
                cur_valid_next = 1'b0;
                cur_id_next    = '0;
                cur_prio_next  = '0;
                res_action     = ppps_pkg::ACT_STOP;
            end
        end
    end

    assign out_load = cmd.exec || cmd.apply;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg  <= 1'b0;
            cur_id_reg     <= '0;
            cur_prio_reg   <= '0;
            pend_valid_reg <= '0;
            count_reg      <= '0;
        end else begin
            cur_valid_reg  <= cur_valid_next;
            cur_id_reg     <= cur_id_next;
            cur_prio_reg   <= cur_prio_next;
            pend_valid_reg <= pend_valid_next;
            count_reg      <= count_next;
        end
    end

    // Table memories
    assign rd_addr = cmd.scan_step ? scan_idx_reg : best_idx_reg;

    always_ff @(posedge aclk) begin
        if (wr_prio_en) begin
            prio_mem[wr_addr] <= wr_prio;
        end
        if (wr_pos_en) begin
            pos_mem[wr_addr] <= wr_pos;
        end
        rd_prio_reg <= prio_mem[rd_addr];
        rd_pos_reg  <= pos_mem[rd_addr];
    end

    // Scan: address the table, then compare the registered read in the next cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_active_reg <= 1'b0;
        end else begin
            cmp_active_reg <= cmd.scan_step;
        end
    end

    always_ff @(posedge aclk) begin
        cmp_idx_reg <= scan_idx_reg;
        cmp_vld_reg <= pend_valid_reg[scan_idx_reg];
        if (cmd.scan_start) begin
            scan_idx_reg <= '0;
        end else if (cmd.scan_step) begin
            scan_idx_reg <= scan_idx_reg + IDX_W'(1);
        end
        // strict compare keeps the lowest index on ties
        if (cmd.scan_start) begin
            found_reg <= 1'b0;
        end else if (cmp_active_reg && cmp_vld_reg &&
                     (!found_reg || rd_prio_reg > best_prio_reg)) begin
            found_reg     <= 1'b1;
            best_idx_reg  <= cmp_idx_reg;
            best_prio_reg <= rd_prio_reg;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_action_reg  <= res_action;
            out_id_reg      <= res_id;
            out_pos_reg     <= res_pos;
            out_playing_reg <= cur_valid_next;
            out_count_reg   <= ppps_pkg::COUNT_W'(count_next);
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_action         = out_action_reg;
    assign m_play_id        = out_id_reg;
    assign m_start_position = out_pos_reg;
    assign m_playing        = out_playing_reg;
    assign m_pending_count  = out_count_reg;

endmodule

FILE: rtl/core/preemptive_priority_playback_scheduler.sv
`timescale 1ns / 1ps
// ============================================================================
// preemptive_priority_playback_scheduler
// Top level: sequencer plus datapath of the playback scheduler.
// ============================================================================
// Usage:
//   Requests enter on s_* (valid/ready): kind (submit, cancel, finished),
//   client_id, priority_req and the current client's playback position.
//   Each request yields exactly one result on m_* (valid/ready): action
//   (none, start, stop), play_id, start_position, playing, pending_count.
// Timing:
//   One request is worked at a time. A submit, a cancel of a pending client
//   or an ignored request is decoded in EXEC, which loads its result.
//   A finish or a cancel of the current client scans the pending table one
//   entry per cycle through the table's single read port, then passes
//   DRAIN, FETCH and APPLY before its result is loaded. s_ready returns the
//   cycle after the result is loaded.
// Stall:
//   The result sits in an output register; a new request is accepted while
//   it waits. If the receiver still holds the previous result when the next
//   one is ready, the sequencer waits with the state unchanged.
// Reset:
//   aresetn (synchronous, active low) empties the pending table, drops the
//   current client and clears m_valid. Stored priorities and positions are
//   not cleared; they are only read behind their valid bits.
// ============================================================================
module preemptive_priority_playback_scheduler #(
    parameter int CLIENTS       = ppps_pkg::CLIENTS_DEF,
    parameter int POSITION_BITS = ppps_pkg::POS_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [ppps_pkg::KIND_W-1:0]  s_kind,
    input  logic [ppps_pkg::ID_W-1:0]    s_client_id,
    input  logic [ppps_pkg::PRIO_W-1:0]  s_priority_req,
    input  logic [ppps_pkg::POS_W-1:0]   s_current_position,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [ppps_pkg::ACT_W-1:0]   m_action,
    output logic [ppps_pkg::ID_W-1:0]    m_play_id,
    output logic [ppps_pkg::POS_W-1:0]   m_start_position,
    output logic                         m_playing,
    output logic [ppps_pkg::COUNT_W-1:0] m_pending_count
);

    ppps_pkg::dp_cmd_t  cmd;
    ppps_pkg::dp_stat_t stat;

    // Sequencer: decides which datapath step runs each cycle
    ppps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Datapath: request capture, table, scan compare and result register
    ppps_dp #(
        .CLIENTS       (CLIENTS),
        .POSITION_BITS (POSITION_BITS)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .stat               (stat),
        .s_kind             (s_kind),
        .s_client_id        (s_client_id),
        .s_priority_req     (s_priority_req),
        .s_current_position (s_current_position),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_action           (m_action),
        .m_play_id          (m_play_id),
        .m_start_position   (m_start_position),
        .m_playing          (m_playing),
        .m_pending_count    (m_pending_count)
    );

endmodule

FILE: rtl/core/ppps_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// ppps_checker
// Port-level checks of the playback scheduler, bound to the top level.
// ============================================================================
module ppps_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [ppps_pkg::ACT_W-1:0]   m_action,
    input logic [ppps_pkg::ID_W-1:0]    m_play_id,
    input logic [ppps_pkg::POS_W-1:0]   m_start_position,
    input logic                         m_playing,
    input logic [ppps_pkg::COUNT_W-1:0] m_pending_count
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid &&
            $stable({m_action, m_play_id, m_start_position, m_playing, m_pending_count}))
        else $error("stalled result changed");

    // one request in flight
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request accepted while busy");

    a_start_plays: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_action == ppps_pkg::ACT_START |-> m_playing)
        else $error("start without a current client");

    a_stop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_action == ppps_pkg::ACT_STOP |-> !m_playing && m_pending_count == '0)
        else $error("idle while clients are pending");

endmodule

bind preemptive_priority_playback_scheduler ppps_checker u_ppps_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_action         (m_action),
    .m_play_id        (m_play_id),
    .m_start_position (m_start_position),
    .m_playing        (m_playing),
    .m_pending_count  (m_pending_count)
);

FILE: tb/tb_preemptive_priority_playback_scheduler.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_preemptive_priority_playback_scheduler
// Self-checking bench for the preemptive priority playback scheduler.
// ============================================================================
// A queue of requests is filled by the sequencing block: a directed walk
// through start, restart, re-arm, enqueue, preempt, remove, promote (with a
// priority tie) and every ignored case, then random traffic in several
// idling phases and one back-pressure phase. A clocked driver moves the
// queue onto the s_ channel; each accepted request runs through a scheduler
// predictor here, whose expected result is queued. A clocked monitor pops
// one expectation per result taken on m_ and compares it field by field.
// ============================================================================
module tb_preemptive_priority_playback_scheduler;
    import ppps_pkg::*;

    localparam int CLIENTS      = CLIENTS_DEF;
    localparam int LIMIT_CYCLES = 400_000;
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int DRAIN_CYCLES = 40;    // > one full scan plus output stage

    // Kind code the block must ignore
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [POS_W-1:0]  pos;
    } sched_req_t;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [ID_W-1:0]    play_id;
        logic [POS_W-1:0]   start_pos;
        logic               playing;
        logic [COUNT_W-1:0] pend_count;
    } sched_result_t;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT ports (all inputs known from time zero)
    // ------------------------------------------------------------------------
    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [KIND_W-1:0]  s_kind = KIND_SUBMIT;
    logic [ID_W-1:0]    s_client_id = '0;
    logic [PRIO_W-1:0]  s_priority_req = '0;
    logic [POS_W-1:0]   s_current_position = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [ACT_W-1:0]   m_action;
    logic [ID_W-1:0]    m_play_id;
    logic [POS_W-1:0]   m_start_position;
    logic               m_playing;
    logic [COUNT_W-1:0] m_pending_count;

    preemptive_priority_playback_scheduler uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_kind             (s_kind),
        .s_client_id        (s_client_id),
        .s_priority_req     (s_priority_req),
        .s_current_position (s_current_position),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_action           (m_action),
        .m_play_id          (m_play_id),
        .m_start_position   (m_start_position),
        .m_playing          (m_playing),
        .m_pending_count    (m_pending_count)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    sched_req_t    req_q[$];       // requests waiting for the driver
    sched_result_t outcome_q[$];   // predicted results, oldest first

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    logic hold_start = 1'b0;
    int hold_cnt = 0;
    int cycle_cnt = 0;
    int errors = 0;

    // coverage-style tallies for the closing summary
    int n_accepted = 0;
    int n_results  = 0;
    int n_in_stall = 0;
    int n_start = 0, n_preempt = 0, n_rearm = 0, n_enqueue = 0;
    int n_remove = 0, n_promote = 0, n_stop = 0;

    // ------------------------------------------------------------------------
    // Scheduler predictor: own copy of the current slot and pending table
    // ------------------------------------------------------------------------
    logic [CLIENTS-1:0] pend_valid = '0;
    logic [PRIO_W-1:0]  pend_prio [CLIENTS];
    logic [POS_W-1:0]   pend_pos  [CLIENTS];
    logic               cur_valid = 1'b0;
    logic [ID_W-1:0]    cur_id = '0;
    logic [PRIO_W-1:0]  cur_prio = '0;

    // Make a client current from position zero; its pending entry goes away.
    function automatic sched_result_t start_client(logic [ID_W-1:0] id,
                                                   logic [PRIO_W-1:0] prio);
        sched_result_t res;
        res = '0;
        pend_valid[id] = 1'b0;
        cur_valid = 1'b1;
        cur_id = id;
        cur_prio = prio;
        res.action = ACT_START;
        res.play_id = id;
        return res;
    endfunction

    // Current client stops: best pending entry resumes (lowest index wins a
    // tie, hence the strict compare), or the output goes idle.
    function automatic sched_result_t promote_best();
        sched_result_t res;
        logic found;
        int best;
        res = '0;
        found = 1'b0;
        best = 0;
        cur_valid = 1'b0;
        cur_id = '0;
        cur_prio = '0;
        for (int i = 0; i < CLIENTS; i++) begin
            if (pend_valid[i] && (!found || pend_prio[i] > pend_prio[best])) begin
                found = 1'b1;
                best = i;
            end
        end
        if (found) begin
            pend_valid[best] = 1'b0;
            cur_valid = 1'b1;
            cur_id = best[ID_W-1:0];
            cur_prio = pend_prio[best];
            res.action = ACT_START;
            res.play_id = best[ID_W-1:0];
            res.start_pos = pend_pos[best];
            n_promote++;
        end else begin
            res.action = ACT_STOP;
            n_stop++;
        end
        return res;
    endfunction

    function automatic sched_result_t schedule_request(sched_req_t r);
        sched_result_t res;
        res = '0;
        case (r.kind)
            KIND_SUBMIT: begin
                if (!cur_valid || cur_id == r.id) begin
                    res = start_client(r.id, r.prio);
                    n_start++;
                end else if (pend_valid[r.id]) begin
                    // re-arm: resume from the top, priority kept
                    pend_pos[r.id] = '0;
                    n_rearm++;
                end else if (r.prio > cur_prio) begin
                    // preempt: park the current client where it stands
                    pend_valid[cur_id] = 1'b1;
                    pend_prio[cur_id] = cur_prio;
                    pend_pos[cur_id] = r.pos;
                    res = start_client(r.id, r.prio);
                    n_preempt++;
                end else begin
                    pend_valid[r.id] = 1'b1;
                    pend_prio[r.id] = r.prio;
                    pend_pos[r.id] = '0;
                    n_enqueue++;
                end
            end
            KIND_CANCEL: begin
                if (cur_valid && cur_id == r.id) begin
                    res = promote_best();
                end else if (pend_valid[r.id]) begin
                    pend_valid[r.id] = 1'b0;
                    n_remove++;
                end
            end
            KIND_FINISH: begin
                if (cur_valid)
                    res = promote_best();
            end
            default: ;
        endcase
        res.playing = cur_valid;
        res.pend_count = COUNT_W'($countones(pend_valid));
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: request channel, fed from req_q
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : drive_proc
        sched_req_t nxt;
        sched_req_t got;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                got = {s_kind, s_client_id, s_priority_req, s_current_position};
                outcome_q.push_back(schedule_request(got));
                n_accepted++;
            end
            if (s_valid && !s_ready)
                n_in_stall++;
            // slot is free after this edge: offer the next request or idle
            if (!s_valid || s_ready) begin
                if (req_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    nxt = req_q.pop_front();
                    s_valid <= 1'b1;
                    s_kind <= nxt.kind;
                    s_client_id <= nxt.id;
                    s_priority_req <= nxt.prio;
                    s_current_position <= nxt.pos;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls plus a long hold-off counted here
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_start)
            hold_cnt <= HOLD_CYCLES;
        else if (hold_cnt != 0)
            hold_cnt <= hold_cnt - 1;
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= (hold_cnt == 0) && !hold_start &&
                       ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each taken result with the oldest prediction
    // ------------------------------------------------------------------------
    task automatic check_field(string name, logic [31:0] want, logic [31:0] seen);
        if (want !== seen) begin
            $display("%0t: mismatch on %s: expected 0x%0h, actual 0x%0h",
                     $time, name, want, seen);
            errors++;
        end
    endtask

    always @(posedge aclk) begin : check_proc
        sched_result_t want;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (outcome_q.size() == 0) begin
                $display("%0t: result with no request pending: action=%0d id=%0d pos=0x%0h",
                         $time, m_action, m_play_id, m_start_position);
                errors++;
            end else begin
                want = outcome_q.pop_front();
                check_field("action", 32'(want.action), 32'(m_action));
                check_field("play_id", 32'(want.play_id), 32'(m_play_id));
                check_field("start_position", want.start_pos, m_start_position);
                check_field("playing", 32'(want.playing), 32'(m_playing));
                check_field("pending_count", 32'(want.pend_count), 32'(m_pending_count));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("%0t: timeout, %0d predictions still open", $time, outcome_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic push_req(logic [KIND_W-1:0] k, logic [ID_W-1:0] id,
                            logic [PRIO_W-1:0] p, logic [POS_W-1:0] pos);
        sched_req_t r;
        r = {k, id, p, pos};
        req_q.push_back(r);
    endtask

    // Mostly live sequences: ids drawn often from a small pool so cancels
    // and re-submits hit current and pending clients; small priorities
    // give ties, extremes hit the compare edges.
    task automatic queue_random(int n);
        sched_req_t r;
        int roll;
        repeat (n) begin
            roll = $urandom_range(99);
            if (roll < 52)
                r.kind = KIND_SUBMIT;
            else if (roll < 72)
                r.kind = KIND_CANCEL;
            else if (roll < 95)
                r.kind = KIND_FINISH;
            else
                r.kind = KIND_UNUSED;
            r.id = $urandom_range(1) ? ID_W'($urandom_range(3)) : ID_W'($urandom_range(15));
            case ($urandom_range(3))
                0: r.prio = PRIO_W'($urandom_range(7));
                1: r.prio = $urandom_range(1) ? '1 : '0;
                default: r.prio = PRIO_W'($urandom_range(255));
            endcase
            case ($urandom_range(7))
                0: r.pos = '0;
                1: r.pos = '1;
                default: r.pos = $urandom();
            endcase
            req_q.push_back(r);
        end
    endtask

    task automatic run_phase(int n, int s_idle, int r_stall);
        sender_idle_pct = s_idle;
        recv_stall_pct = r_stall;
        queue_random(n);
        while (req_q.size() != 0)
            @(negedge aclk);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        // all bench-side updates happen on the falling edge from here on
        @(negedge aclk);

        // --- directed walk, no idling ---
        push_req(KIND_FINISH, 0, 0, 0);                   // finish with nothing playing
        push_req(KIND_CANCEL, 9, 0, 0);                   // cancel of unknown client
        push_req(KIND_UNUSED, 15, 8'hFF, 32'hFFFF_FFFF);  // unused kind, all bits high
        push_req(KIND_SUBMIT, 0, 8'h00, 32'hFFFF_FFFF);   // idle -> start at 0
        push_req(KIND_SUBMIT, 0, 8'hFF, 32'hDEAD_BEEF);   // restart of current
        push_req(KIND_SUBMIT, 5, 8'd10, 32'h0000_0001);   // enqueue
        push_req(KIND_SUBMIT, 5, 8'd200, 32'h5555_5555);  // re-arm, priority kept
        push_req(KIND_SUBMIT, 15, 8'hFF, 32'hAAAA_AAAA);  // equal priority -> enqueue
        push_req(KIND_CANCEL, 5, 0, 0);                   // remove pending
        push_req(KIND_SUBMIT, 3, 8'h00, 0);               // enqueue at priority 0
        push_req(KIND_FINISH, 0, 0, 0);                   // promote 15
        push_req(KIND_SUBMIT, 7, 8'd100, 0);
        push_req(KIND_SUBMIT, 9, 8'd100, 0);              // tie with 7
        push_req(KIND_CANCEL, 15, 0, 0);                  // cancel current, 7 wins tie
        push_req(KIND_SUBMIT, 12, 8'd200, 32'hFFFF_FFFF); // preempt 7
        push_req(KIND_SUBMIT, 1, 8'd201, 32'h1234_5678);  // preempt 12
        push_req(KIND_FINISH, 0, 0, 0);                   // resume 12
        push_req(KIND_FINISH, 0, 0, 0);                   // resume 7 at all-ones
        push_req(KIND_FINISH, 0, 0, 0);                   // 9
        push_req(KIND_FINISH, 0, 0, 0);                   // 3
        push_req(KIND_FINISH, 0, 0, 0);                   // table empty -> stop
        push_req(KIND_SUBMIT, 2, 8'h00, 0);
        push_req(KIND_SUBMIT, 4, 8'h01, 32'h8000_0000);   // preempt lowest by one
        push_req(KIND_CANCEL, 4, 0, 0);                   // 2 resumes at saved position
        push_req(KIND_CANCEL, 2, 0, 0);                   // stop
        while (req_q.size() != 0)
            @(negedge aclk);

        // --- random phases ---
        run_phase(500, 0, 0);
        run_phase(350, 83, 0);
        run_phase(350, 0, 83);
        run_phase(400, 24, 24);

        // back-pressure: receiver holds off while the sender keeps offering
        hold_start = 1'b1;
        @(negedge aclk);
        hold_start = 1'b0;
        run_phase(100, 0, 0);

        // drain: nothing queued, nothing on the bus, nothing predicted
        while (req_q.size() != 0 || s_valid || outcome_q.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (outcome_q.size() != 0) begin
            $display("%0t: %0d predicted results never arrived", $time, outcome_q.size());
            errors++;
        end

        $display("Covered %0d requests / %0d results: %0d starts, %0d preemptions, %0d re-arms,",
                 n_accepted, n_results, n_start, n_preempt, n_rearm);
        $display("  %0d enqueues, %0d removals, %0d promotions, %0d stops, %0d input stall cycles",
                 n_enqueue, n_remove, n_promote, n_stop, n_in_stall);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d errors", errors);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/ppps_pkg.sv
rtl/core/ppps_ctrl.sv
rtl/core/ppps_dp.sv
rtl/core/preemptive_priority_playback_scheduler.sv
rtl/core/ppps_checker.sv
tb/tb_preemptive_priority_playback_scheduler.sv
